[rtl/crc8fb_pkg.sv]
// Package with the transaction types, frame constants and CRC function of the frame builder.
package crc8fb_pkg;

	// Frame delimiters and the reflected CRC-8 polynomial.
	localparam logic [7:0] FRAME_HEADER = 8'h12;
	localparam logic [7:0] FRAME_TAIL   = 8'h13;
	localparam logic [7:0] CRC_POLY     = 8'hD5;

	// One input transaction: a payload byte and its end-of-frame flag.
	typedef struct packed {
		logic [7:0] payload_byte;
		logic       last_in_frame;
	} in_t;

	// One output transaction: a frame byte and the tail marker.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       end_of_frame;
	} out_t;

	// Everything the output sequencer needs to emit the bytes of one item.
	typedef struct packed {
		logic [7:0] payload_byte;
		logic [7:0] crc;
		logic       need_header;
		logic       need_tail;
	} slot_t;

	// Output sequencer phases, one-hot.
	typedef enum logic [3:0] {
		PH_HEADER  = 4'b0001,
		PH_PAYLOAD = 4'b0010,
		PH_CRC     = 4'b0100,
		PH_TAIL    = 4'b1000
	} phase_t;

	// Byte-wide LSB-first CRC-8 update; the eight bit steps flatten into XOR logic.
	function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		logic       mix;
		c = crc;
		for (int k = 0; k < 8; k++) begin
			mix = c[0] ^ data[k];
			c = {1'b0, c[7:1]};
			if (mix) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

endpackage

[rtl/crc8_frame_builder.sv]
// Top level of the CRC-8 serial frame builder.
// Takes one payload byte per transaction and emits the frame one byte per output transaction:
// header 0x12 before the first payload byte, each payload byte unchanged, and after the byte
// flagged last the reflected CRC-8 (polynomial 0xD5, LSB first, starting at 0, payload only)
// followed by tail 0x13 with end_of_frame set. The output side moves one byte per cycle while
// the output is not stalled, and an item yields 1 to 4 bytes: 1 for a byte inside a frame, 2
// for a frame's first byte, 3 for its last, 4 for a single-byte frame. An item is taken in
// the same cycle the previous item's final byte enters the output register, so middle bytes
// stream at one item per cycle unless stalled; the CRC is updated when an item is accepted.
module crc8_frame_builder (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  crc8fb_pkg::in_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output crc8fb_pkg::out_t  result
);

	logic              inside_frame_q;
	logic [7:0]        running_crc_q;
	logic [7:0]        crc_start;
	logic [7:0]        crc_next;
	logic              accept;
	logic              seq_ready;
	crc8fb_pkg::slot_t slot;

	assign accept     = item_valid && seq_ready;
	assign item_stall = !seq_ready;

	// CRC of the frame so far including this byte; a new frame starts from zero.
	assign crc_start = inside_frame_q ? running_crc_q : 8'h00;
	assign crc_next  = crc8fb_pkg::crc_update(crc_start, item.payload_byte);

	// Prepared item handed to the output sequencer.
	always_comb begin
		slot.payload_byte = item.payload_byte;
		slot.crc          = crc_next;
		slot.need_header  = !inside_frame_q;
		slot.need_tail    = item.last_in_frame;
	end

	// Frame state, advanced at each accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_frame_q <= 1'b0;
			running_crc_q  <= 8'h00;
		end else if (accept) begin
			inside_frame_q <= !item.last_in_frame;
			running_crc_q  <= item.last_in_frame ? 8'h00 : crc_next;
		end
	end

	crc8fb_out_seq u_out_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.load_valid   (item_valid),
		.load_slot    (slot),
		.load_ready   (seq_ready),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

[rtl/crc8fb_out_seq.sv]
// Output sequencer: holds one prepared item and emits its frame bytes through an output register.
module crc8fb_out_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load_valid,
	input  crc8fb_pkg::slot_t  load_slot,
	output logic               load_ready,
	output logic               result_valid,
	input  logic               result_stall,
	output crc8fb_pkg::out_t   result
);

	crc8fb_pkg::slot_t  slot_s1;
	logic               slot_valid_s1;
	crc8fb_pkg::phase_t phase_q;
	crc8fb_pkg::phase_t phase_next;
	logic               result_valid_q;
	crc8fb_pkg::out_t   result_q;
	crc8fb_pkg::out_t   emit_data;
	logic               out_load;
	logic               emit;
	logic               final_byte;
	logic               done;

	// The output register takes a new byte when empty or when its byte is taken.
	assign out_load   = !result_valid_q || !result_stall;
	assign emit       = slot_valid_s1 && out_load;
	assign final_byte = (phase_q == crc8fb_pkg::PH_TAIL) ||
	                    ((phase_q == crc8fb_pkg::PH_PAYLOAD) && !slot_s1.need_tail);
	assign done       = emit && final_byte;
	assign load_ready = !slot_valid_s1 || done;

	// Select the byte of the current phase and the phase after it.
	always_comb begin
		emit_data.end_of_frame = 1'b0;
		case (phase_q)
			crc8fb_pkg::PH_HEADER: begin
				emit_data.out_byte = crc8fb_pkg::FRAME_HEADER;
				phase_next         = crc8fb_pkg::PH_PAYLOAD;
			end
			crc8fb_pkg::PH_PAYLOAD: begin
				emit_data.out_byte = slot_s1.payload_byte;
				phase_next         = crc8fb_pkg::PH_CRC;
			end
			crc8fb_pkg::PH_CRC: begin
				emit_data.out_byte = slot_s1.crc;
				phase_next         = crc8fb_pkg::PH_TAIL;
			end
			crc8fb_pkg::PH_TAIL: begin
				emit_data.out_byte     = crc8fb_pkg::FRAME_TAIL;
				emit_data.end_of_frame = 1'b1;
				phase_next             = crc8fb_pkg::PH_HEADER;
			end
			default: begin
				emit_data.out_byte = slot_s1.payload_byte;
				phase_next         = crc8fb_pkg::PH_HEADER;
			end
		endcase
	end

	// Item stage: load a new item when empty or as the previous one finishes, else retire or step the phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_s1 <= 1'b0;
			phase_q       <= crc8fb_pkg::PH_HEADER;
		end else if (load_valid && load_ready) begin
			slot_valid_s1 <= 1'b1;
			phase_q       <= load_slot.need_header ? crc8fb_pkg::PH_HEADER
			                                       : crc8fb_pkg::PH_PAYLOAD;
		end else if (done) begin
			slot_valid_s1 <= 1'b0;
		end else if (emit) begin
			phase_q <= phase_next;
		end
	end

	// Item payload register.
	always_ff @(posedge clk) begin
		if (load_valid && load_ready) begin
			slot_s1 <= load_slot;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= slot_valid_s1;
		end
	end

	// Output register data.
	always_ff @(posedge clk) begin
		if (emit) begin
			result_q <= emit_data;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

[rtl/crc8fb_checker.sv]
// Port-level checker for the frame builder and its bind to the top level.
module crc8fb_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_stall,
	input crc8fb_pkg::in_t  item,
	input logic             result_valid,
	input logic             result_stall,
	input crc8fb_pkg::out_t result
);

	logic result_accept;
	logic expect_header_q;

	assign result_accept = result_valid && !result_stall;

	// Track where the output stream is: a header is due after reset and after each tail.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_header_q <= 1'b1;
		end else if (result_accept) begin
			expect_header_q <= result.end_of_frame;
		end
	end

	// A stalled output transaction stays valid and keeps its data.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("output transaction changed while stalled");

	// A stalled input transaction stays offered and keeps its data.
	a_item_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_stall |=> item_valid && $stable(item))
		else $error("input transaction changed while stalled");

	// The first byte of every frame is the header.
	a_header_first: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && expect_header_q |-> result.out_byte == crc8fb_pkg::FRAME_HEADER &&
		!result.end_of_frame)
		else $error("frame does not open with the header byte");

	// The end-of-frame marker rides only on the tail byte.
	a_tail_byte: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.end_of_frame |-> result.out_byte == crc8fb_pkg::FRAME_TAIL)
		else $error("end of frame marked on a byte other than the tail");

endmodule

bind crc8_frame_builder crc8fb_checker u_crc8fb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
